/* hdl/assert_macros.svh */
// assertion helpers included by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// implication checked on every edge outside reset
`define CHK_IMPL(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication outside reset
`define CHK_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`endif

/* hdl/gprg_pkg.sv */
package gprg_pkg;
  localparam int NUM_KEYS = 19;
  localparam int AVG_SAMPLES = 4;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [2:0] CFG_KEY_DEB = 3'd0;
  localparam logic [2:0] CFG_MUX_DEB = 3'd1;
  localparam logic [2:0] CFG_LOW_THR = 3'd2;
  localparam logic [2:0] CFG_HIGH_THR = 3'd3;
  localparam logic [2:0] CFG_HOLD = 3'd4;
  localparam logic [2:0] CFG_RESEND = 3'd5;
  localparam logic [2:0] CFG_IDLE = 3'd6;

  localparam int SEL_KEY_IDX = 12;
  localparam int START_KEY_IDX = 13;
  localparam int TURBO3_KEY_IDX = 14;
  localparam int TURBO2_KEY_IDX = 15;
  localparam int MODE_KEY_IDX = 16;
  localparam int TURBO_KEY_IDX = 17;
  localparam int AUTO_KEY_IDX = 18;

  localparam logic [7:0] AXIS_CENTER = 8'h80;

  // classified tick handed from front to back
  typedef struct packed {
    logic [15:0] mask;
    logic [3:0]  hat;
    logic [3:0]  left_dir;
    logic [3:0]  right_dir;
    logic        mapping;
    logic [7:0]  ax0;
    logic [7:0]  ax1;
    logic [7:0]  ax2;
    logic [7:0]  ax3;
    logic        connected;
  } tick_t;

  typedef struct packed {
    logic [15:0] button_bits;
    logic [7:0]  axis_x;
    logic [7:0]  axis_y;
    logic [7:0]  axis_z;
    logic [7:0]  axis_rz;
    logic [3:0]  hat_code;
  } report_t;

  function automatic logic [3:0] hat_lookup(input logic [3:0] d);
    logic [3:0] r;
    unique case (d)
      4'd1: r = 4'd1;
      4'd2: r = 4'd3;
      4'd3: r = 4'd2;
      4'd4: r = 4'd5;
      4'd6: r = 4'd4;
      4'd8: r = 4'd7;
      4'd9: r = 4'd8;
      4'd12: r = 4'd6;
      default: r = 4'd0;
    endcase
    return r;
  endfunction

  function automatic logic [3:0] classify(input logic [7:0] vy, input logic [7:0] vx,
                                          input logic [7:0] lo, input logic [7:0] hi);
    logic [3:0] d;
    d = 4'd0;
    if (vy <= lo) d[0] = 1'b1;
    if (vy >= hi) d[2] = 1'b1;
    if (vx <= lo) d[3] = 1'b1;
    if (vx >= hi) d[1] = 1'b1;
    return d;
  endfunction
endpackage

/* hdl/gprg_front.sv */
module gprg_front import gprg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        step,
  input  logic [18:0] key_levels,
  input  logic [11:0] sx0,
  input  logic [11:0] sx1,
  input  logic [11:0] sx2,
  input  logic [11:0] sx3,
  input  logic        connected,
  input  logic [3:0]  key_deb,
  input  logic [3:0]  mux_deb,
  input  logic [7:0]  low_thr,
  input  logic [7:0]  high_thr,
  output tick_t       tick
);
  logic [3:0]  cnt_r [NUM_KEYS];
  logic [3:0]  cnt_nxt [NUM_KEYS];
  logic [18:0] keys_r, keys_nxt;
  logic        phase_r, mode_r, mode_nxt;
  logic [13:0] sum_r [4];
  logic [13:0] sum_nxt [4];
  logic [11:0] smp [4];
  logic [1:0]  scnt_r;
  logic [7:0]  ax_r [4];
  logic [7:0]  ax_nxt [4];
  logic [3:0]  ldir_r, rdir_r, ldir_nxt, rdir_nxt;

  assign smp[0] = sx0;
  assign smp[1] = sx1;
  assign smp[2] = sx2;
  assign smp[3] = sx3;

  // per-key debounce
  always_comb begin
    logic muxed, skip, lvl;
    logic [4:0] c;
    keys_nxt = keys_r;
    mode_nxt = mode_r;
    for (int i = 0; i < NUM_KEYS; i++) begin
      muxed = (i == SEL_KEY_IDX) || (i == TURBO2_KEY_IDX) || (i == TURBO_KEY_IDX);
      skip = phase_r ? ((i == START_KEY_IDX) || (i == AUTO_KEY_IDX) ||
                        (i == TURBO3_KEY_IDX)) : muxed;
      lvl = muxed ? key_levels[i] : ~key_levels[i];
      c = {1'b0, cnt_r[i]} + 5'd1;
      cnt_nxt[i] = cnt_r[i];
      if (!skip) begin
        if (lvl != keys_r[i]) begin
          if (c >= {1'b0, (muxed ? mux_deb : key_deb)}) begin
            cnt_nxt[i] = 4'd0;
            keys_nxt[i] = lvl;
            if (lvl && i == MODE_KEY_IDX) mode_nxt = ~mode_r;
          end else begin
            cnt_nxt[i] = c[3:0];
          end
        end else begin
          cnt_nxt[i] = 4'd0;
        end
      end
    end
  end

  // stick averaging and classification
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      sum_nxt[i] = sum_r[i] + {2'b00, ~smp[i]};
      ax_nxt[i] = (scnt_r == 2'd3) ? sum_nxt[i][13:6] : ax_r[i];
    end
    ldir_nxt = (scnt_r == 2'd3) ? classify(ax_nxt[1], ax_nxt[0], low_thr, high_thr) : ldir_r;
    rdir_nxt = (scnt_r == 2'd3) ? classify(ax_nxt[3], ax_nxt[2], low_thr, high_thr) : rdir_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < NUM_KEYS; i++) cnt_r[i] <= 4'd0;
      for (int i = 0; i < 4; i++) begin
        sum_r[i] <= 14'd0;
        ax_r[i] <= 8'd0;
      end
      keys_r <= '0;
      phase_r <= 1'b0;
      mode_r <= 1'b0;
      scnt_r <= 2'd0;
      ldir_r <= 4'd0;
      rdir_r <= 4'd0;
    end else if (step) begin
      for (int i = 0; i < NUM_KEYS; i++) cnt_r[i] <= cnt_nxt[i];
      for (int i = 0; i < 4; i++) begin
        sum_r[i] <= (scnt_r == 2'd3) ? 14'd0 : sum_nxt[i];
        ax_r[i] <= ax_nxt[i];
      end
      keys_r <= keys_nxt;
      phase_r <= ~phase_r;
      mode_r <= mode_nxt;
      scnt_r <= scnt_r + 2'd1;
      ldir_r <= ldir_nxt;
      rdir_r <= rdir_nxt;
    end
  end

  // build the classified tick from the post-update state
  always_comb begin
    logic [3:0] h;
    h = keys_nxt[3:0];
    tick.mask = {4'd0, keys_nxt[15:4]};
    if (mode_nxt) begin
      if (h == 4'd0) h = ldir_nxt;
      tick.mask[3:0] = tick.mask[3:0] | rdir_nxt;
    end
    tick.hat = hat_lookup(h);
    tick.left_dir = ldir_nxt;
    tick.right_dir = rdir_nxt;
    tick.mapping = mode_nxt;
    tick.ax0 = ax_nxt[0];
    tick.ax1 = ax_nxt[1];
    tick.ax2 = ax_nxt[2];
    tick.ax3 = ax_nxt[3];
    tick.connected = connected;
  end
endmodule

/* hdl/gprg_queue.sv */
module gprg_queue import gprg_pkg::*; #(
  parameter int WIDTH = 8,
  parameter int DEPTH = QUEUE_DEPTH
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             wr,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             rd,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0] cnt_r;

  assign full = (cnt_r == (AW+1)'(DEPTH));
  assign empty = (cnt_r == '0);
  assign rdata = mem_r[rp_r];

  // pointers wrap at depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0;
      rp_r <= '0;
      cnt_r <= '0;
    end else begin
      if (wr) wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + 1'b1;
      if (rd) rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(wr) - (AW+1)'(rd);
    end
  end

  always_ff @(posedge clk) begin
    if (wr) mem_r[wp_r] <= wdata;
  end
endmodule

/* hdl/gprg_back.sv */
module gprg_back import gprg_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        q_empty,
  input  tick_t       tick,
  output logic        q_pop,
  input  logic [12:0] hold_ticks,
  input  logic [6:0]  resend,
  input  logic [6:0]  idle,
  output logic        rep_push,
  output report_t     rep,
  input  logic        rep_full
);
  logic [15:0] sb_r;
  logic [3:0]  sh_r, sl_r, sr_r;
  logic [12:0] hold_r, hold_nxt;
  logic [6:0]  dly_r, dly_nxt;
  logic        send;

  // a tick may be retired once the report queue has room
  assign q_pop = !q_empty && !rep_full;

  // send throttle
  always_comb begin
    dly_nxt = dly_r;
    hold_nxt = hold_r;
    if (sl_r != tick.left_dir || sr_r != tick.right_dir) begin
      dly_nxt = 7'd0;
      if (!tick.mapping) hold_nxt = hold_ticks;
    end else if (sb_r != tick.mask || sh_r != tick.hat) begin
      dly_nxt = 7'd0;
    end else if (hold_r != 13'd0) begin
      if (dly_r != 7'd0) dly_nxt = dly_r - 7'd1;
    end else begin
      dly_nxt = idle;
    end
    if (hold_nxt != 13'd0) hold_nxt = hold_nxt - 13'd1;
    send = tick.connected && (dly_nxt == 7'd0);
  end

  assign rep_push = q_pop && send;
  assign rep.button_bits = tick.mask;
  assign rep.axis_x = tick.mapping ? AXIS_CENTER : tick.ax0;
  assign rep.axis_y = tick.mapping ? AXIS_CENTER : tick.ax1;
  assign rep.axis_z = tick.mapping ? AXIS_CENTER : tick.ax2;
  assign rep.axis_rz = tick.mapping ? AXIS_CENTER : tick.ax3;
  assign rep.hat_code = tick.hat;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sb_r <= '0;
      sh_r <= '0;
      sl_r <= '0;
      sr_r <= '0;
      hold_r <= '0;
      dly_r <= '0;
    end else if (q_pop && tick.connected) begin
      hold_r <= hold_nxt;
      dly_r <= send ? resend : dly_nxt;
      if (send) begin
        sb_r <= tick.mask;
        sh_r <= tick.hat;
        sl_r <= tick.left_dir;
        sr_r <= tick.right_dir;
      end
    end
  end
endmodule

/* hdl/gamepad_report_generator.sv */
// gamepad report generator: one tick accepted per cycle while not full
// a tick is held in the tick queue and its report, if sent, in the report queue
// throughput: one tick per cycle while reports are popped; a full report queue
// stalls the back end, and a full tick queue then raises in_full
// reset: synchronous active-low; clears all key, stick and send state,
// loads default configuration
module gamepad_report_generator import gprg_pkg::*; #(
  parameter int QDEPTH = QUEUE_DEPTH
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [18:0] in_key_levels,
  input  logic [11:0] in_left_stick_x,
  input  logic [11:0] in_left_stick_y,
  input  logic [11:0] in_right_stick_x,
  input  logic [11:0] in_right_stick_y,
  input  logic        in_link_connected,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [15:0] out_button_bits,
  output logic [7:0]  out_axis_x,
  output logic [7:0]  out_axis_y,
  output logic [7:0]  out_axis_z,
  output logic [7:0]  out_axis_rz,
  output logic [3:0]  out_hat_code,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data
);
  logic [3:0]  key_deb_r, mux_deb_r;
  logic [7:0]  low_r, high_r;
  logic [12:0] hold_r;
  logic [6:0]  resend_r, idle_r;
  tick_t   tick_in, tick_out;
  report_t rep_in, rep_out;
  logic step, tq_empty, tq_pop, rq_push, rq_full;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key_deb_r <= 4'd5;
      mux_deb_r <= 4'd8;
      low_r <= 8'd96;
      high_r <= 8'd160;
      hold_r <= 13'd5000;
      resend_r <= 7'd25;
      idle_r <= 7'd100;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_KEY_DEB: key_deb_r <= cfg_data[3:0];
        CFG_MUX_DEB: mux_deb_r <= cfg_data[3:0];
        CFG_LOW_THR: low_r <= cfg_data[7:0];
        CFG_HIGH_THR: high_r <= cfg_data[7:0];
        CFG_HOLD: hold_r <= cfg_data;
        CFG_RESEND: resend_r <= cfg_data[6:0];
        CFG_IDLE: idle_r <= cfg_data[6:0];
        default: ;
      endcase
    end
  end

  assign step = in_push && !in_full;

  gprg_front u_front (
    .clk, .rst_n, .step,
    .key_levels(in_key_levels),
    .sx0(in_left_stick_x), .sx1(in_left_stick_y),
    .sx2(in_right_stick_x), .sx3(in_right_stick_y),
    .connected(in_link_connected),
    .key_deb(key_deb_r), .mux_deb(mux_deb_r),
    .low_thr(low_r), .high_thr(high_r),
    .tick(tick_in)
  );

  gprg_queue #(.WIDTH($bits(tick_t)), .DEPTH(QDEPTH)) u_tq (
    .clk, .rst_n, .wr(step), .wdata(tick_in), .full(in_full),
    .rd(tq_pop), .rdata(tick_out), .empty(tq_empty)
  );

  gprg_back u_back (
    .clk, .rst_n, .q_empty(tq_empty), .tick(tick_out), .q_pop(tq_pop),
    .hold_ticks(hold_r), .resend(resend_r), .idle(idle_r),
    .rep_push(rq_push), .rep(rep_in), .rep_full(rq_full)
  );

  gprg_queue #(.WIDTH($bits(report_t)), .DEPTH(QDEPTH)) u_rq (
    .clk, .rst_n, .wr(rq_push), .wdata(rep_in), .full(rq_full),
    .rd(out_pop && !out_empty), .rdata(rep_out), .empty(out_empty)
  );

  assign out_button_bits = rep_out.button_bits;
  assign out_axis_x = rep_out.axis_x;
  assign out_axis_y = rep_out.axis_y;
  assign out_axis_z = rep_out.axis_z;
  assign out_axis_rz = rep_out.axis_rz;
  assign out_hat_code = rep_out.hat_code;
endmodule

/* hdl/gprg_checker.sv */
`include "assert_macros.svh"
module gprg_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_empty,
  input logic        out_pop,
  input logic [15:0] out_button_bits,
  input logic [3:0]  out_hat_code
);
  // hat code is never above eight
  `CHK_IMPL(a_hat_range, clk, rst_n, !out_empty, out_hat_code <= 4'd8, "hat out of range")
  // a stalled result holds
  `CHK_NEXT(a_hold, clk, rst_n, !out_empty && !out_pop, $stable(out_button_bits), "result moved")
  // buttons above bit eleven stay clear
  `CHK_IMPL(a_upper, clk, rst_n, !out_empty, out_button_bits[15:12] == 4'd0, "bad buttons")
  // no result appears in the cycle after reset release without a request
  `CHK_NEXT(a_nospont, clk, rst_n, $rose(rst_n), out_empty, "result out of reset")
endmodule

bind gamepad_report_generator gprg_checker u_chk (
  .clk, .rst_n, .out_empty, .out_pop, .out_button_bits, .out_hat_code
);
